// File: rtl/lpm_pkg.sv
// Shared types, constants and helpers for the IPv4 longest-prefix-match table.
package lpm_pkg;

  localparam int TableEntries = 256;
  localparam int MaxValues    = 8;
  localparam int ValueBits    = 16;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [1:0] ST_BAD_LEN    = 2'd2;
  localparam logic [1:0] ST_LIST_FULL  = 2'd3;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic [15:0] value_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [15:0] result_value;
    logic [5:0]  match_len;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_MOD,
    S_VREAD,
    S_VWAIT,
    S_DONE
  } state_t;

  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    begin
      if (len == 6'd0) m = 32'h0;
      else if (len >= 6'd32) m = 32'hffff_ffff;
      else m = 32'hffff_ffff << (6'd32 - len);
      return m;
    end
  endfunction

endpackage

// File: rtl/lpm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ipv4_longest_prefix_match.sv
// Top level of the IPv4 longest-prefix-match table with per-prefix value lists.
// Every insert or lookup scans the entry memory once, one read per cycle, then passes
// through a drain state. A lookup hit then reduces the address modulo the value count
// bit-serially and reads the selected value; an insert or a miss goes from the modulo
// state straight to the result, and a bad length cuts the scan short. A new item is
// taken only in idle with no result pending. Reset clears valid bits and control state.
module ipv4_longest_prefix_match #(
  parameter int TABLE_ENTRIES = lpm_pkg::TableEntries,
  parameter int MAX_VALUES    = lpm_pkg::MaxValues,
  parameter int VALUE_BITS    = lpm_pkg::ValueBits
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lpm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lpm_pkg::out_item_t out_data
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(MAX_VALUES + 1);
  localparam int SW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int VD = TABLE_ENTRIES << SW;  // one power-of-two slot group per entry
  localparam int VW = $clog2(VD);
  localparam int EW = 38 + CW;  // prefix, length and value count per entry
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VALUES);

  // Valid bits live in flops so reset clears them at once; counts sit in the
  // entry memory and are only read for valid entries.
  logic [TABLE_ENTRIES-1:0] valid_r;

  lpm_pkg::state_t state_r, state_nxt;
  lpm_pkg::in_item_t item_r;
  logic [31:0] net_r;
  logic [IW:0] scan_r;            // read address counter
  logic        rd_vld_r;          // entry read data valid this cycle
  logic [IW-1:0] rd_idx_r;
  logic        hit_r, free_r, bad_r;
  logic [IW-1:0] best_r, free_idx_r;
  logic [5:0]  best_len_r;
  logic [CW-1:0] best_cnt_r;
  logic [5:0]  mod_cnt_r;
  logic [CW-1:0] rem_r;
  logic [SW-1:0] slot_r;
  logic        out_valid_r;
  lpm_pkg::out_item_t out_r, out_nxt;

  // Entry memory: prefix, length and count.
  logic          e_we;
  logic [IW-1:0] e_waddr;
  logic [EW-1:0] e_wdata, e_rdata;
  lpm_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(scan_r[IW-1:0]), .rdata(e_rdata)
  );

  // Value memory.
  logic          v_we;
  logic [VW-1:0] v_waddr, v_raddr;
  logic [VALUE_BITS-1:0] v_wdata, v_rdata;
  lpm_ram #(.WIDTH(VALUE_BITS), .DEPTH(VD)) u_value_ram (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  wire [31:0]   e_prefix = e_rdata[EW-1:CW+6];
  wire [5:0]    e_len    = e_rdata[CW+5:CW];
  wire [CW-1:0] e_cnt    = e_rdata[CW-1:0];
  wire        e_valid  = valid_r[rd_idx_r];
  wire        e_match_lookup = e_valid && e_len <= 6'd32 &&
                               ((item_r.address & lpm_pkg::len_mask(e_len)) == e_prefix);
  wire        e_match_insert = e_valid && e_len == item_r.prefix_len && e_prefix == net_r;
  wire        scan_last = (scan_r == (IW+1)'(TABLE_ENTRIES));

  // One step of the restoring remainder, address MSB first.
  wire [4:0]    mod_idx = 5'(mod_cnt_r - 6'd1);
  wire [CW:0]   mod_t   = {rem_r, item_r.address[mod_idx]};
  wire [CW-1:0] rem_nxt = (mod_t >= {1'b0, best_cnt_r}) ?
                          CW'(mod_t - {1'b0, best_cnt_r}) : mod_t[CW-1:0];

  assign in_stall  = (state_r != lpm_pkg::S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpm_pkg::S_IDLE:  if (in_valid && !in_stall) state_nxt = lpm_pkg::S_SCAN;
      lpm_pkg::S_SCAN:  if (bad_r) state_nxt = lpm_pkg::S_DONE;
                        else if (scan_last) state_nxt = lpm_pkg::S_DRAIN;
      lpm_pkg::S_DRAIN: state_nxt = lpm_pkg::S_MOD;
      lpm_pkg::S_MOD:   if (item_r.action == lpm_pkg::ACT_INSERT || !hit_r)
                          state_nxt = lpm_pkg::S_DONE;
                        else if (mod_cnt_r == 6'd0) state_nxt = lpm_pkg::S_VREAD;
      lpm_pkg::S_VREAD: state_nxt = lpm_pkg::S_VWAIT;
      lpm_pkg::S_VWAIT: state_nxt = lpm_pkg::S_DONE;
      lpm_pkg::S_DONE:  state_nxt = lpm_pkg::S_IDLE;
      default:          state_nxt = lpm_pkg::S_IDLE;
    endcase
  end

  // Insert commit and value read address.
  always_comb begin
    e_we    = 1'b0;
    e_waddr = free_idx_r;
    e_wdata = {net_r, item_r.prefix_len, CW'(1)};
    v_we    = 1'b0;
    v_waddr = VW'({free_idx_r, SW'(0)});
    v_wdata = item_r.value_id[VALUE_BITS-1:0];
    v_raddr = VW'({best_r, slot_r});
    if (state_r == lpm_pkg::S_MOD && item_r.action == lpm_pkg::ACT_INSERT) begin
      if (hit_r) begin
        // Append: bump the count in place, store the value in the next slot.
        if (best_cnt_r < MAX_CNT) begin
          e_we    = 1'b1;
          e_waddr = best_r;
          e_wdata = {net_r, item_r.prefix_len, CW'(best_cnt_r + 1'b1)};
          v_we    = 1'b1;
          v_waddr = VW'({best_r, SW'(best_cnt_r)});
        end
      end else if (free_r) begin
        e_we = 1'b1;
        v_we = 1'b1;
      end
    end
  end

  // Result of the finished transaction.
  always_comb begin
    out_nxt        = '0;
    out_nxt.status = lpm_pkg::ST_OK;
    if (bad_r) out_nxt.status = lpm_pkg::ST_BAD_LEN;
    else if (item_r.action == lpm_pkg::ACT_INSERT) begin
      if (hit_r && best_cnt_r >= MAX_CNT) out_nxt.status = lpm_pkg::ST_LIST_FULL;
      else if (!hit_r && !free_r) out_nxt.status = lpm_pkg::ST_TABLE_FULL;
    end else if (hit_r) begin
      out_nxt.found        = 1'b1;
      out_nxt.result_value = 16'(v_rdata);
      out_nxt.match_len    = best_len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpm_pkg::S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        lpm_pkg::S_IDLE: begin
          if (in_valid && !in_stall) begin
            item_r     <= in_data;
            net_r      <= in_data.address & lpm_pkg::len_mask(in_data.prefix_len);
            bad_r      <= in_data.action == lpm_pkg::ACT_INSERT &&
                          in_data.prefix_len > 6'd32;
            scan_r     <= '0;
            rd_vld_r   <= 1'b0;
            hit_r      <= 1'b0;
            free_r     <= 1'b0;
            best_len_r <= '0;
            best_cnt_r <= '0;
            best_r     <= '0;
            free_idx_r <= '0;
          end
        end
        lpm_pkg::S_SCAN, lpm_pkg::S_DRAIN: begin
          // Advance the read address; evaluate the entry read last cycle.
          if (!scan_last) scan_r <= scan_r + 1'b1;
          rd_vld_r <= !scan_last;
          rd_idx_r <= scan_r[IW-1:0];
          if (rd_vld_r) begin
            if (item_r.action == lpm_pkg::ACT_LOOKUP) begin
              if (e_match_lookup && (!hit_r || e_len > best_len_r)) begin
                hit_r <= 1'b1; best_r <= rd_idx_r; best_len_r <= e_len;
                best_cnt_r <= e_cnt;
              end
            end else begin
              if (e_match_insert && !hit_r) begin
                hit_r <= 1'b1; best_r <= rd_idx_r; best_cnt_r <= e_cnt;
              end
            end
            if (!valid_r[rd_idx_r] && !free_r) begin
              free_r <= 1'b1; free_idx_r <= rd_idx_r;
            end
          end
          rem_r     <= '0;
          mod_cnt_r <= 6'd32;
        end
        lpm_pkg::S_MOD: begin
          if (item_r.action == lpm_pkg::ACT_INSERT) begin
            if (!hit_r && free_r) valid_r[free_idx_r] <= 1'b1;
          end else if (hit_r && mod_cnt_r != 6'd0) begin
            // One bit of address modulo count per cycle, MSB first.
            rem_r     <= rem_nxt;
            mod_cnt_r <= mod_cnt_r - 6'd1;
          end
        end
        lpm_pkg::S_VREAD: slot_r <= (best_cnt_r > CW'(1)) ? SW'(rem_r) : '0;
        lpm_pkg::S_DONE: begin
          out_valid_r <= 1'b1;
          out_r       <= out_nxt;
        end
        default: ;
      endcase
    end
  end

  // The value read address must settle before the read data is used.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lpm_pkg::S_VWAIT |-> $past(state_r) == lpm_pkg::S_VREAD)
    else $error("value read skipped");
  // A result is only raised from the final state.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == lpm_pkg::S_DONE)
    else $error("result raised outside done");
  // No new transaction while a result waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> in_stall)
    else $error("input open while result pending");

endmodule
